// ===== design/acp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acp_pkg;

   localparam int MAX_VALUE_LEN = 7;
   localparam int STORE_DEPTH   = 7;
   localparam int COUNT_W       = 3;

   localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
   localparam logic [7:0] CH_G     = 8'h67;  // 'g'
   localparam logic [7:0] CH_S     = 8'h73;  // 's'
   localparam logic [7:0] CH_T     = 8'h74;  // 't'
   localparam logic [7:0] CH_A     = 8'h61;  // 'a'
   localparam logic [7:0] CH_C     = 8'h63;  // 'c'
   localparam logic [7:0] CH_E     = 8'h65;  // 'e'
   localparam logic [7:0] CH_SEMI  = 8'h3b;  // ';'
   localparam logic [7:0] CH_COMMA = 8'h2c;  // ','
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_SET = 1'b1;

   localparam logic [1:0] PARAM_TEMP   = 2'd0;
   localparam logic [1:0] PARAM_HEATER = 2'd1;
   localparam logic [1:0] PARAM_COOLER = 2'd2;
   localparam logic [1:0] PARAM_ENABLE = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_READY = 3'd1,
      PH_GET   = 3'd2,
      PH_SET   = 3'd3,
      PH_PARAM = 3'd4,
      PH_VALUE = 3'd5
   } phase_type;

   typedef struct packed {
      logic                         kind;
      logic [1:0]                   param;
      logic [COUNT_W-1:0]           len;
      logic [STORE_DEPTH-1:0][7:0]  bytes;
   } result_type;

   function automatic logic is_param_letter(input logic [7:0] b, input logic allow_e);
      logic ok;
      case (b)
         CH_T, CH_A, CH_C: ok = 1'b1;
         CH_E:             ok = allow_e;
         default:          ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [1:0] param_of(input logic [7:0] b);
      logic [1:0] code;
      case (b)
         CH_A:    code = PARAM_HEATER;
         CH_C:    code = PARAM_COOLER;
         CH_E:    code = PARAM_ENABLE;
         default: code = PARAM_TEMP;
      endcase
      return code;
   endfunction

   function automatic logic is_value_char(input logic [7:0] b);
      return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_COMMA);
   endfunction

endpackage

`default_nettype wire

// ===== design/acp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acp_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          rx_byte,
   output acp_pkg::result_type      result,
   output logic                     emit
);

   acp_pkg::phase_type                 phase_ff, phase_in;
   logic [1:0]                         param_ff, param_in;
   logic [acp_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [7:0]                         store_ff [acp_pkg::STORE_DEPTH];
   logic                               store_we;
   logic                               kind;
   logic [acp_pkg::COUNT_W-1:0]        len;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= acp_pkg::PH_IDLE;
         param_ff <= 2'd0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         param_ff <= param_in;
         count_ff <= count_in;
      end
   end

   // value store has no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (step && store_we) begin
         store_ff[count_ff] <= rx_byte;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      param_in = param_ff;
      count_in = count_ff;
      store_we = 1'b0;
      emit     = 1'b0;
      kind     = acp_pkg::KIND_GET;
      len      = '0;
      if (rx_byte == acp_pkg::CH_HASH) begin
         phase_in = acp_pkg::PH_READY;
      end else begin
         unique case (phase_ff)
            acp_pkg::PH_READY: begin
               if (rx_byte == acp_pkg::CH_G)      phase_in = acp_pkg::PH_GET;
               else if (rx_byte == acp_pkg::CH_S) phase_in = acp_pkg::PH_SET;
               else                               phase_in = acp_pkg::PH_IDLE;
            end
            acp_pkg::PH_GET: begin
               if (acp_pkg::is_param_letter(rx_byte, 1'b0)) begin
                  param_in = acp_pkg::param_of(rx_byte);
                  phase_in = acp_pkg::PH_PARAM;
               end else begin
                  phase_in = acp_pkg::PH_IDLE;
               end
            end
            acp_pkg::PH_SET: begin
               if (acp_pkg::is_param_letter(rx_byte, 1'b1)) begin
                  param_in = acp_pkg::param_of(rx_byte);
                  count_in = '0;
                  phase_in = acp_pkg::PH_VALUE;
               end else begin
                  phase_in = acp_pkg::PH_IDLE;
               end
            end
            acp_pkg::PH_PARAM: begin
               emit     = step && (rx_byte == acp_pkg::CH_SEMI);
               phase_in = acp_pkg::PH_IDLE;
            end
            acp_pkg::PH_VALUE: begin
               if (acp_pkg::is_value_char(rx_byte)) begin
                  // bytes past the limit are dropped, frame stays alive
                  if (count_ff < acp_pkg::COUNT_W'(acp_pkg::MAX_VALUE_LEN)) begin
                     store_we = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  emit     = step && (rx_byte == acp_pkg::CH_SEMI);
                  kind     = acp_pkg::KIND_SET;
                  len      = count_ff;
                  phase_in = acp_pkg::PH_IDLE;
               end
            end
            default: phase_in = acp_pkg::PH_IDLE;
         endcase
      end
   end

   always_comb begin
      result.kind  = kind;
      result.param = param_ff;
      result.len   = len;
      for (int i = 0; i < acp_pkg::STORE_DEPTH; i++) begin
         result.bytes[i] = (acp_pkg::COUNT_W'(i) < len) ? store_ff[i] : 8'h00;
      end
   end

endmodule

`default_nettype wire

// ===== design/ascii_get_set_command_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A byte that completes a frame is registered in the input stage, then its command in the rsp_ output register.
// Throughput: one byte per cycle while the parse stage is not held; it updates phase, param and count together.
// The parse stage holds only while a finished command waits on rsp_ready.
// Reset (synchronous): clears phase to idle, param and count to zero, and both valid flags;
// the value store is not reset.

module ascii_get_set_command_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_command_kind,
   output logic [1:0]       rsp_param_code,
   output logic [2:0]       rsp_value_length,
   output logic [7:0]       rsp_value_byte0,
   output logic [7:0]       rsp_value_byte1,
   output logic [7:0]       rsp_value_byte2,
   output logic [7:0]       rsp_value_byte3,
   output logic [7:0]       rsp_value_byte4,
   output logic [7:0]       rsp_value_byte5,
   output logic [7:0]       rsp_value_byte6
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   advance;
   logic                   core_emit;
   acp_pkg::result_type    core_result;
   logic                   rsp_valid_ff, rsp_valid_in;
   acp_pkg::result_type    rsp_data_ff;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
   end

   acp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (core_result),
      .emit    (core_emit)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_emit)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_emit) rsp_data_ff <= core_result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_kind = rsp_data_ff.kind;
   assign rsp_param_code   = rsp_data_ff.param;
   assign rsp_value_length = rsp_data_ff.len;
   assign rsp_value_byte0  = rsp_data_ff.bytes[0];
   assign rsp_value_byte1  = rsp_data_ff.bytes[1];
   assign rsp_value_byte2  = rsp_data_ff.bytes[2];
   assign rsp_value_byte3  = rsp_data_ff.bytes[3];
   assign rsp_value_byte4  = rsp_data_ff.bytes[4];
   assign rsp_value_byte5  = rsp_data_ff.bytes[5];
   assign rsp_value_byte6  = rsp_data_ff.bytes[6];

   // a new command never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      core_emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("command emitted while output register full");

   a_get_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_kind == acp_pkg::KIND_GET) |-> (rsp_value_length == 3'd0))
      else $error("get command carries value bytes");

   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_value_length != 3'd7) |-> (rsp_value_byte6 == 8'h00))
      else $error("value byte past length not zero");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

endmodule

`default_nettype wire

// ===== dv/ascii_get_set_command_parser_tb.sv =====
`timescale 1ns / 1ps

module ascii_get_set_command_parser_tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      logic [7:0]          rx;
      bit                  typed;
      acp_pkg::result_type cmd;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_command_kind;
   logic [1:0] rsp_param_code;
   logic [2:0] rsp_value_length;
   logic [7:0] rsp_value_byte0, rsp_value_byte1, rsp_value_byte2, rsp_value_byte3;
   logic [7:0] rsp_value_byte4, rsp_value_byte5, rsp_value_byte6;

   // shadow copy of the parser state
   acp_pkg::phase_type  sh_phase;
   logic [1:0]          sh_param;
   logic [2:0]          sh_count;
   logic [7:0]          sh_store [acp_pkg::STORE_DEPTH];

   acp_pkg::result_type pending_cmds[$];
   dir_row_type         dir_rows[$];
   logic [7:0]          frame_q[$];
   acp_pkg::result_type seen_cmd, want_cmd;

   int  cycles    = 0;
   int  bad_cmds  = 0;
   int  n_bytes   = 0;
   int  n_live    = 0;
   int  n_get     = 0;
   int  n_set     = 0;
   int  n_dropped = 0;
   bit  burst     = 1'b0;

   ascii_get_set_command_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_kind (rsp_command_kind),
      .rsp_param_code   (rsp_param_code),
      .rsp_value_length (rsp_value_length),
      .rsp_value_byte0  (rsp_value_byte0),
      .rsp_value_byte1  (rsp_value_byte1),
      .rsp_value_byte2  (rsp_value_byte2),
      .rsp_value_byte3  (rsp_value_byte3),
      .rsp_value_byte4  (rsp_value_byte4),
      .rsp_value_byte5  (rsp_value_byte5),
      .rsp_value_byte6  (rsp_value_byte6)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d commands outstanding",
                  cycles, pending_cmds.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // full-range junk or a byte from the command alphabet
   function automatic logic [7:0] pick_noise();
      logic [7:0] ch;
      ch = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 11))
         0: ch = acp_pkg::CH_HASH;
         1: ch = acp_pkg::CH_G;
         2: ch = acp_pkg::CH_S;
         3: ch = acp_pkg::CH_T;
         4: ch = acp_pkg::CH_A;
         5: ch = acp_pkg::CH_C;
         6: ch = acp_pkg::CH_E;
         7: ch = acp_pkg::CH_SEMI;
         8: ch = acp_pkg::CH_COMMA;
         default: ;
      endcase
      return ch;
   endfunction

   function automatic acp_pkg::result_type mk_cmd(logic kind, logic [1:0] param,
                                                  logic [2:0] len, string text);
      acp_pkg::result_type c;
      int i;
      c = '0;
      c.kind = kind;
      c.param = param;
      c.len = len;
      for (i = 0; i < text.len(); i++) c.bytes[i] = text[i];
      return c;
   endfunction

   task automatic add_row(logic [7:0] b, bit typed, acp_pkg::result_type c);
      dir_row_type row;
      row.rx = b;
      row.typed = typed;
      row.cmd = c;
      dir_rows.push_back(row);
   endtask

   task automatic add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) add_row(s[i], 1'b0, '0);
   endtask

   // advance the shadow parser by one byte; hit flags a finished command
   task automatic parse_byte(input logic [7:0] b, output bit hit,
                             output acp_pkg::result_type cmd);
      logic [1:0] code;
      bit found;
      int i;
      hit = 1'b0;
      cmd = '0;
      code = acp_pkg::PARAM_TEMP;
      if (b == acp_pkg::CH_HASH) begin
         sh_phase = acp_pkg::PH_READY;
      end else begin
         case (sh_phase)
            acp_pkg::PH_READY: begin
               if (b == acp_pkg::CH_G) sh_phase = acp_pkg::PH_GET;
               else if (b == acp_pkg::CH_S) sh_phase = acp_pkg::PH_SET;
               else sh_phase = acp_pkg::PH_IDLE;
            end
            acp_pkg::PH_GET, acp_pkg::PH_SET: begin
               found = 1'b1;
               case (b)
                  acp_pkg::CH_T: code = acp_pkg::PARAM_TEMP;
                  acp_pkg::CH_A: code = acp_pkg::PARAM_HEATER;
                  acp_pkg::CH_C: code = acp_pkg::PARAM_COOLER;
                  acp_pkg::CH_E: begin
                     code = acp_pkg::PARAM_ENABLE;
                     found = (sh_phase == acp_pkg::PH_SET);
                  end
                  default: found = 1'b0;
               endcase
               if (!found) begin
                  sh_phase = acp_pkg::PH_IDLE;
               end else begin
                  sh_param = code;
                  if (sh_phase == acp_pkg::PH_SET) begin
                     sh_count = '0;
                     sh_phase = acp_pkg::PH_VALUE;
                  end else begin
                     sh_phase = acp_pkg::PH_PARAM;
                  end
               end
            end
            acp_pkg::PH_PARAM: begin
               if (b == acp_pkg::CH_SEMI) begin
                  hit = 1'b1;
                  cmd.kind = acp_pkg::KIND_GET;
                  cmd.param = sh_param;
               end
               sh_phase = acp_pkg::PH_IDLE;
            end
            acp_pkg::PH_VALUE: begin
               if ((b >= acp_pkg::CH_ZERO && b <= acp_pkg::CH_NINE) ||
                   b == acp_pkg::CH_COMMA) begin
                  if (sh_count < acp_pkg::MAX_VALUE_LEN) begin
                     sh_store[sh_count] = b;
                     sh_count++;
                  end else begin
                     n_dropped++;
                  end
               end else begin
                  if (b == acp_pkg::CH_SEMI) begin
                     hit = 1'b1;
                     cmd.kind = acp_pkg::KIND_SET;
                     cmd.param = sh_param;
                     cmd.len = sh_count;
                     for (i = 0; i < sh_count; i++) cmd.bytes[i] = sh_store[i];
                  end
                  sh_phase = acp_pkg::PH_IDLE;
               end
            end
            default: sh_phase = acp_pkg::PH_IDLE;
         endcase
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input acp_pkg::result_type typed_cmd);
      bit hit;
      acp_pkg::result_type cmd;
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_bytes++;
      if (sh_phase != acp_pkg::PH_IDLE || b == acp_pkg::CH_HASH) n_live++;
      parse_byte(b, hit, cmd);
      if (typed) pending_cmds.push_back(typed_cmd);
      else if (hit) pending_cmds.push_back(cmd);
   endtask

   // mostly well-formed frames with random content, some broken, some junk
   task automatic build_frame();
      int sort, n;
      bit is_set;
      logic [7:0] ch;
      frame_q.delete();
      sort = $urandom_range(0, 9);
      if (sort < 8) begin
         is_set = 1'($urandom_range(0, 1));
         frame_q.push_back(acp_pkg::CH_HASH);
         frame_q.push_back(is_set ? acp_pkg::CH_S : acp_pkg::CH_G);
         case ($urandom_range(0, is_set ? 3 : 2))
            0: ch = acp_pkg::CH_T;
            1: ch = acp_pkg::CH_A;
            2: ch = acp_pkg::CH_C;
            default: ch = acp_pkg::CH_E;
         endcase
         frame_q.push_back(ch);
         if (is_set) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 7);
            repeat (n) begin
               if ($urandom_range(0, 10) == 10) ch = acp_pkg::CH_COMMA;
               else ch = acp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
               frame_q.push_back(ch);
            end
         end
         if ($urandom_range(0, 19) != 0) frame_q.push_back(acp_pkg::CH_SEMI);
         if ($urandom_range(0, 7) == 0)
            frame_q[$urandom_range(0, frame_q.size() - 1)] = pick_noise();
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) frame_q.push_back(pick_noise());
      end
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_cmd.kind     = rsp_command_kind;
         seen_cmd.param    = rsp_param_code;
         seen_cmd.len      = rsp_value_length;
         seen_cmd.bytes[0] = rsp_value_byte0;
         seen_cmd.bytes[1] = rsp_value_byte1;
         seen_cmd.bytes[2] = rsp_value_byte2;
         seen_cmd.bytes[3] = rsp_value_byte3;
         seen_cmd.bytes[4] = rsp_value_byte4;
         seen_cmd.bytes[5] = rsp_value_byte5;
         seen_cmd.bytes[6] = rsp_value_byte6;
         if (seen_cmd.kind === acp_pkg::KIND_SET) n_set++;
         else n_get++;
         if (pending_cmds.size() == 0) begin
            if (bad_cmds < 10)
               $display("ERROR cycle %0d: unexpected command kind=%0d param=%0d len=%0d %h",
                        cycles, seen_cmd.kind, seen_cmd.param, seen_cmd.len, seen_cmd.bytes);
            bad_cmds++;
         end else begin
            want_cmd = pending_cmds.pop_front();
            if (seen_cmd.kind !== want_cmd.kind || seen_cmd.param !== want_cmd.param ||
                seen_cmd.len !== want_cmd.len || seen_cmd.bytes !== want_cmd.bytes) begin
               if (bad_cmds < 10) begin
                  $display("ERROR cycle %0d: expected kind=%0d param=%0d len=%0d %h", cycles,
                           want_cmd.kind, want_cmd.param, want_cmd.len, want_cmd.bytes);
                  $display("                 actual   kind=%0d param=%0d len=%0d %h",
                           seen_cmd.kind, seen_cmd.param, seen_cmd.len, seen_cmd.bytes);
               end
               bad_cmds++;
            end
         end
      end
   end

   // response-side backpressure
   initial begin
      int stall, run;
      forever begin
         stall = pick_gap();
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         run = $urandom_range(1, 12);
         repeat (run) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int k, bytes_start;
      sh_phase = acp_pkg::PH_IDLE;
      sh_param = '0;
      sh_count = '0;
      for (k = 0; k < acp_pkg::STORE_DEPTH; k++) sh_store[k] = 8'h00;

      add_row(8'h00, 1'b0, '0);                   // ignored while idle
      add_text("#gt");
      add_row(acp_pkg::CH_SEMI, 1'b1,
              mk_cmd(acp_pkg::KIND_GET, acp_pkg::PARAM_TEMP, 3'd0, ""));
      add_text("#gc");
      add_row(8'hFF, 1'b0, '0);                   // junk after get letter aborts
      add_text("#se9#sc");                        // restart mid-value, then empty set
      add_row(acp_pkg::CH_SEMI, 1'b1,
              mk_cmd(acp_pkg::KIND_SET, acp_pkg::PARAM_COOLER, 3'd0, ""));
      add_text("#sa012345,9");                    // eighth value char is dropped
      add_row(acp_pkg::CH_SEMI, 1'b1,
              mk_cmd(acp_pkg::KIND_SET, acp_pkg::PARAM_HEATER, 3'd7, "012345,"));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) send_byte(dir_rows[k].rx, dir_rows[k].typed, dir_rows[k].cmd);

      bytes_start = n_bytes;
      while (n_bytes - bytes_start < RANDOM_ITEMS) begin
         build_frame();
         foreach (frame_q[k]) send_byte(frame_q[k], 1'b0, '0);
         if ($urandom_range(0, 29) == 0) burst = !burst;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_cmds.size() != 0) bad_cmds++;

      $display("Sent %0d bytes (%0d parsed outside idle), checked %0d get / %0d set commands",
               n_bytes, n_live, n_get, n_set);
      $display("Overflow value chars dropped: %0d, bad commands: %0d", n_dropped, bad_cmds);
      if (bad_cmds == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
